### rtl/core/alfo_pkg.sv
// Package for the linear stereo fade-out block: widths, register map,
// reset values and the request and result payload structs.
// Depends on nothing; every block file refers to it by scoped names.
package alfo_pkg;

   // Sample and counter widths.
   localparam int SampleBits = 16;
   localparam int PosBits    = 32;
   localparam int LenBits    = 24;
   localparam int CntBits    = $clog2(SampleBits);

   // Configuration port geometry and register indexes.
   localparam int CsrDataBits = 32;
   localparam int CsrAddrBits = 3;
   localparam logic RegFadeStart  = 1'b0;
   localparam logic RegFadeLength = 1'b1;

   // Register reset values and the saturation point of the position.
   localparam logic [PosBits-1:0] FadeStartReset  = '0;
   localparam logic [LenBits-1:0] FadeLengthReset = LenBits'(336000);
   localparam logic [PosBits-1:0] PosMax          = '1;

   // One stereo sample pair with its flags.
   typedef struct packed {
      logic signed [SampleBits-1:0] left_in;
      logic signed [SampleBits-1:0] right_in;
      logic                         restart;
      logic                         block_end;
   } req_payload_type;

   // One faded sample pair with its status flags.
   typedef struct packed {
      logic signed [SampleBits-1:0] left_out;
      logic signed [SampleBits-1:0] right_out;
      logic                         fading;
      logic                         block_end_out;
   } rsp_payload_type;

endpackage

### rtl/core/audio_linear_fade_out.sv
// Linear fade-out for a stereo PCM stream, one sample pair per request.
// Uses alfo_pkg for widths, register map and payload structs.
//
// Requests arrive on req_valid/req_ready with a req_data struct holding
// the left and right samples, a restart flag that clears the sample
// position first, and a block_end flag that is passed through. Results
// leave on rsp_valid/rsp_ready in rsp_data. Two registers sit on the
// csr_ APB port: fade_start at byte 0 and fade_length at byte 4; write
// them only while no request is in flight.
// Each channel is scaled by remaining / fade_length with truncation
// toward zero. One shared multiply-divide step unit forms the product
// and quotient together, one sample bit per cycle, first for the left
// channel and then for the right. A request inside the fade passes
// through an accept state, an evaluation state, one step per sample bit
// for each channel and a hand-off state. A request before the fade
// start or past its end skips the steps and goes from evaluation
// straight to the hand-off.
// A stalled receiver holds the result in the output register while the
// block works on the next request until that result needs the register.
// Reset clears the position, sets fade_start to 0 and fade_length to
// 336000, and empties the output.
module audio_linear_fade_out (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  alfo_pkg::req_payload_type           req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output alfo_pkg::rsp_payload_type           rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [alfo_pkg::CsrAddrBits-1:0]    csr_paddr,
   input  logic [alfo_pkg::CsrDataBits-1:0]    csr_pwdata,
   output logic [alfo_pkg::CsrDataBits-1:0]    csr_prdata,
   output logic                                csr_pready
);

   localparam int Sb = alfo_pkg::SampleBits;
   localparam int Lb = alfo_pkg::LenBits;
   localparam int Pb = alfo_pkg::PosBits;
   localparam int Cb = alfo_pkg::CntBits;

   // Sequencer states, one-hot.
   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_EVAL   = 5'b00010,
      S_LEFT   = 5'b00100,
      S_RIGHT  = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type                   state_ff, state_in;
   logic [Pb-1:0]               fade_start_ff, fade_start_in;
   logic [Lb-1:0]               fade_length_ff, fade_length_in;
   logic [Pb-1:0]               pos_ff, pos_in;
   logic [Pb-1:0]               cur_pos_ff, cur_pos_in;
   alfo_pkg::req_payload_type   req_ff, req_in;
   logic [Lb-1:0]               rem_ff, rem_in;
   logic [Lb-1:0]               dlen_ff, dlen_in;
   logic [Lb-1:0]               acc_ff, acc_in;
   logic [Sb-1:0]               quo_ff, quo_in;
   logic [Sb-1:0]               mag_ff, mag_in;
   logic [Cb-1:0]               cnt_ff, cnt_in;
   logic [Sb-1:0]               lres_ff, lres_in;
   logic [Sb-1:0]               rres_ff, rres_in;
   logic                        fading_ff, fading_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   alfo_pkg::rsp_payload_type   rsp_data_ff, rsp_data_in;

   logic                        req_accept;
   logic                        csr_write;
   logic                        out_free;
   logic [Pb-1:0]               pos_eff;
   logic [Pb:0]                 fade_end;
   logic [Pb:0]                 rem_wide;
   logic                        at_start;
   logic                        past_end;
   logic [Sb-1:0]               left_mag;
   logic [Sb-1:0]               right_mag;
   logic [Lb-1:0]               step_add;
   logic [Lb+1:0]               step_sum;
   logic [Lb+1:0]               len_one;
   logic [Lb+1:0]               len_two;
   logic [Lb+1:0]               diff_one;
   logic [Lb+1:0]               diff_two;
   logic [Lb-1:0]               step_acc;
   logic [1:0]                  step_digit;
   logic [Sb-1:0]               step_quo;
   logic [Sb-1:0]               step_signed;
   logic                        step_last;

   // Handshake qualifiers.
   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // Register writes and read-back.
   always_comb begin
      fade_start_in  = fade_start_ff;
      fade_length_in = fade_length_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            alfo_pkg::RegFadeStart:  fade_start_in  = csr_pwdata[Pb-1:0];
            alfo_pkg::RegFadeLength: fade_length_in = csr_pwdata[Lb-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         alfo_pkg::RegFadeStart:  csr_prdata = fade_start_ff;
         alfo_pkg::RegFadeLength: csr_prdata = {{(alfo_pkg::CsrDataBits-Lb){1'b0}},
                                                fade_length_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   // Position of the accepted pair, after a restart clears it.
   assign pos_eff = req_data.restart ? '0 : pos_ff;

   // Fade window tests, formed one bit wider so the end never wraps.
   assign fade_end = {1'b0, fade_start_ff} + {{(Pb+1-Lb){1'b0}}, fade_length_ff};
   assign rem_wide = fade_end - {1'b0, cur_pos_ff};
   assign at_start = (cur_pos_ff >= fade_start_ff);
   assign past_end = ({1'b0, cur_pos_ff} >= fade_end) || (fade_length_ff == '0);

   // Channel magnitudes; the most negative sample maps to its unsigned size.
   assign left_mag  = req_ff.left_in[Sb-1] ? (Sb'(0) - Sb'(req_ff.left_in))
                                           : Sb'(req_ff.left_in);
   assign right_mag = req_ff.right_in[Sb-1] ? (Sb'(0) - Sb'(req_ff.right_in))
                                            : Sb'(req_ff.right_in);

   // Shared step unit: the accumulator takes the next product bit and
   // gives back zero, one or two divisors, which is the next quotient digit.
   // The remainder stays below the divisor after every step.
   assign step_add = mag_ff[Sb-1] ? rem_ff : {Lb{1'b0}};
   assign step_sum = {1'b0, acc_ff, 1'b0} + {2'b00, step_add};
   assign len_one  = {2'b00, dlen_ff};
   assign len_two  = {1'b0, dlen_ff, 1'b0};
   assign diff_one = step_sum - len_one;
   assign diff_two = step_sum - len_two;

   always_comb begin
      priority if (step_sum >= len_two) begin
         step_acc   = diff_two[Lb-1:0];
         step_digit = 2'd2;
      end else if (step_sum >= len_one) begin
         step_acc   = diff_one[Lb-1:0];
         step_digit = 2'd1;
      end else begin
         step_acc   = step_sum[Lb-1:0];
         step_digit = 2'd0;
      end
   end

   assign step_quo  = {quo_ff[Sb-2:0], 1'b0} + {{(Sb-2){1'b0}}, step_digit};
   assign step_last = (cnt_ff == Cb'(Sb - 1));

   // Sign of the channel in work applied to the finished quotient.
   always_comb begin
      if (state_ff == S_LEFT) begin
         step_signed = req_ff.left_in[Sb-1] ? (Sb'(0) - step_quo) : step_quo;
      end else begin
         step_signed = req_ff.right_in[Sb-1] ? (Sb'(0) - step_quo) : step_quo;
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      cur_pos_in   = cur_pos_ff;
      req_in       = req_ff;
      rem_in       = rem_ff;
      dlen_in      = dlen_ff;
      acc_in       = acc_ff;
      quo_in       = quo_ff;
      mag_in       = mag_ff;
      cnt_in       = cnt_ff;
      lres_in      = lres_ff;
      rres_in      = rres_ff;
      fading_in    = fading_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               req_in     = req_data;
               cur_pos_in = pos_eff;
               pos_in     = (pos_eff == alfo_pkg::PosMax) ? pos_eff : pos_eff + 1'b1;
               state_in   = S_EVAL;
            end
         end
         S_EVAL: begin
            // Decide pass-through, silence or a scaled pair.
            fading_in = at_start;
            rem_in    = rem_wide[Lb-1:0];
            dlen_in   = fade_length_ff;
            acc_in    = '0;
            quo_in    = '0;
            cnt_in    = '0;
            mag_in    = left_mag;
            if (!at_start) begin
               lres_in  = req_ff.left_in;
               rres_in  = req_ff.right_in;
               state_in = S_FINISH;
            end else if (past_end) begin
               lres_in  = '0;
               rres_in  = '0;
               state_in = S_FINISH;
            end else begin
               state_in = S_LEFT;
            end
         end
         S_LEFT: begin
            acc_in = step_acc;
            quo_in = step_quo;
            mag_in = {mag_ff[Sb-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (step_last) begin
               lres_in  = step_signed;
               acc_in   = '0;
               quo_in   = '0;
               cnt_in   = '0;
               mag_in   = right_mag;
               state_in = S_RIGHT;
            end
         end
         S_RIGHT: begin
            acc_in = step_acc;
            quo_in = step_quo;
            mag_in = {mag_ff[Sb-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (step_last) begin
               rres_in  = step_signed;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // Hand the pair to the output register once it is free.
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.left_out       = $signed(lres_ff);
               rsp_data_in.right_out      = $signed(rres_ff);
               rsp_data_in.fading         = fading_ff;
               rsp_data_in.block_end_out  = req_ff.block_end;
               state_in                   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         pos_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         fade_start_ff  <= alfo_pkg::FadeStartReset;
         fade_length_ff <= alfo_pkg::FadeLengthReset;
      end else begin
         state_ff       <= state_in;
         pos_ff         <= pos_in;
         rsp_valid_ff   <= rsp_valid_in;
         fade_start_ff  <= fade_start_in;
         fade_length_ff <= fade_length_in;
      end
   end

   // Payload and datapath registers.
   always_ff @(posedge clock) begin
      cur_pos_ff  <= cur_pos_in;
      req_ff      <= req_in;
      rem_ff      <= rem_in;
      dlen_ff     <= dlen_in;
      acc_ff      <= acc_in;
      quo_ff      <= quo_in;
      mag_ff      <= mag_in;
      cnt_ff      <= cnt_in;
      lres_ff     <= lres_in;
      rres_ff     <= rres_in;
      fading_ff   <= fading_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The divider remainder stays below the latched divisor while stepping.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LEFT || state_ff == S_RIGHT) |-> (acc_ff < dlen_ff))
      else $error("divider remainder reached the divisor");

   // The remaining count never exceeds the fade length while stepping.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LEFT || state_ff == S_RIGHT) |-> (rem_ff <= dlen_ff))
      else $error("remaining count above fade length");

   // An accepted request is evaluated in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_EVAL))
      else $error("accepted request not evaluated");

   // The position saturates instead of wrapping.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && !req_data.restart && pos_ff == alfo_pkg::PosMax)
      |=> (pos_ff == alfo_pkg::PosMax))
      else $error("sample position wrapped");

endmodule

### bench/tb.sv
// Self-checking bench for the linear stereo fade-out block: directed and random sample
// pairs, register writes between runs, and result checks against an in-bench predictor.
// Depends on alfo_pkg for the payload structs, widths and register map.
module tb;

   localparam int Sb = alfo_pkg::SampleBits;
   localparam int Pb = alfo_pkg::PosBits;
   localparam int Lb = alfo_pkg::LenBits;
   localparam int Ab = alfo_pkg::CsrAddrBits;
   localparam int Db = alfo_pkg::CsrDataBits;

   typedef logic signed [Sb-1:0] sample_type;

   localparam logic [Ab-1:0] AddrStart  = Ab'(4 * int'(alfo_pkg::RegFadeStart));
   localparam logic [Ab-1:0] AddrLength = Ab'(4 * int'(alfo_pkg::RegFadeLength));
   localparam int RandomPairs = 1875;
   localparam int HoldCycles  = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_ready;
   alfo_pkg::req_payload_type   req_data = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   alfo_pkg::rsp_payload_type   rsp_data;
   logic                        csr_psel = 1'b0;
   logic                        csr_penable = 1'b0;
   logic                        csr_pwrite = 1'b0;
   logic [Ab-1:0]               csr_paddr = '0;
   logic [Db-1:0]               csr_pwdata = '0;
   logic [Db-1:0]               csr_prdata;
   logic                        csr_pready;

   // Mirror of the block's registers and sample position.
   logic [Pb-1:0] start_mirror    = alfo_pkg::FadeStartReset;
   logic [Lb-1:0] length_mirror   = alfo_pkg::FadeLengthReset;
   logic [Pb-1:0] position_mirror = '0;

   alfo_pkg::req_payload_type pending_pairs[$];
   alfo_pkg::rsp_payload_type faded_pairs[$];

   int  mismatches = 0;
   int  received = 0;
   int  holds_done = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   bit  sender_quiet = 1'b0;
   bit  receiver_quiet = 1'b0;

   audio_linear_fade_out dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      if (mismatches < 40) begin
         $display("mismatch at %0t: %s", $time, what);
      end
      mismatches++;
   endtask

   // Idle length for either side: mostly none or short, now and then long.
   function automatic int random_gap(input bit quiet);
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic sample_type pick_sample();
      case ($urandom_range(0, 9))
         0: return sample_type'(16'sh8000);
         1: return sample_type'(16'sh7fff);
         2: return '0;
         3: return '1;
         default: return sample_type'($urandom());
      endcase
   endfunction

   // Gain of remaining / fade_length, truncated toward zero.
   function automatic sample_type scale_sample(input sample_type value,
                                               input logic [Pb:0] remaining);
      longint product;
      product = longint'(value) * longint'(remaining);
      return sample_type'(product / longint'(length_mirror));
   endfunction

   // Expected faded pair for one accepted request; advances the position mirror.
   function automatic alfo_pkg::rsp_payload_type fade_pair(
         input alfo_pkg::req_payload_type pair);
      alfo_pkg::rsp_payload_type faded;
      logic [Pb:0]               fade_end;
      logic [Pb:0]               remaining;
      if (pair.restart) position_mirror = '0;
      faded.left_out      = pair.left_in;
      faded.right_out     = pair.right_in;
      faded.fading        = 1'b0;
      faded.block_end_out = pair.block_end;
      if (position_mirror >= start_mirror) begin
         faded.fading = 1'b1;
         // The end is formed one bit wider than the position so it never wraps.
         fade_end = {1'b0, start_mirror} + length_mirror;
         if (length_mirror == '0 || {1'b0, position_mirror} >= fade_end) begin
            faded.left_out  = '0;
            faded.right_out = '0;
         end else begin
            remaining       = fade_end - {1'b0, position_mirror};
            faded.left_out  = scale_sample(pair.left_in, remaining);
            faded.right_out = scale_sample(pair.right_in, remaining);
         end
      end
      if (position_mirror != alfo_pkg::PosMax) position_mirror = position_mirror + 1'b1;
      return faded;
   endfunction

   // Request driver: holds each pair until accepted, then idles at random.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready) faded_pairs.push_back(fade_pair(req_data));
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
               req_data  <= pending_pairs.pop_front();
               req_valid <= 1'b1;
               send_gap  <= random_gap(sender_quiet);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each accepted result and paces the ready line.
   always @(posedge clock) begin : result_monitor
      alfo_pkg::rsp_payload_type want;
      int                        stall_next;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            received++;
            if (faded_pairs.size() == 0) begin
               report_mismatch("result with no request outstanding");
            end else begin
               want = faded_pairs.pop_front();
               if (rsp_data.left_out !== want.left_out)
                  report_mismatch($sformatf("left_out %0d, expected %0d",
                                            rsp_data.left_out, want.left_out));
               if (rsp_data.right_out !== want.right_out)
                  report_mismatch($sformatf("right_out %0d, expected %0d",
                                            rsp_data.right_out, want.right_out));
               if (rsp_data.fading !== want.fading)
                  report_mismatch($sformatf("fading %b, expected %b",
                                            rsp_data.fading, want.fading));
               if (rsp_data.block_end_out !== want.block_end_out)
                  report_mismatch($sformatf("block_end_out %b, expected %b",
                                            rsp_data.block_end_out, want.block_end_out));
            end
         end
         // A long hold-off twice in the run, while requests are still queued.
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
         end else if (holds_done < 2 && received >= 500 + holds_done * 800 &&
                      pending_pairs.size() > 8) begin
            holds_done++;
            stall_left <= HoldCycles;
            rsp_ready  <= 1'b0;
         end else begin
            stall_next = random_gap(receiver_quiet);
            stall_left <= stall_next;
            rsp_ready  <= (stall_next == 0);
         end
      end
   end

   // One APB transfer: setup cycle, then access until pready.
   task automatic csr_access(input bit write, input logic [Ab-1:0] addr,
                             input logic [Db-1:0] wdata,
                             output logic [Db-1:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic check_registers();
      logic [Db-1:0] value;
      csr_access(1'b0, AddrStart, '0, value);
      if (value !== Db'(start_mirror))
         report_mismatch($sformatf("fade_start reads %h, expected %h", value, start_mirror));
      csr_access(1'b0, AddrLength, '0, value);
      if (value !== Db'(length_mirror))
         report_mismatch($sformatf("fade_length reads %h, expected %h", value, length_mirror));
   endtask

   // Both registers are written with the block idle; upper length bits are dropped.
   task automatic set_fade(input logic [Db-1:0] start,
                           input logic [Db-1:0] length_word);
      logic [Db-1:0] unused;
      csr_access(1'b1, AddrStart, start, unused);
      start_mirror = start;
      csr_access(1'b1, AddrLength, length_word, unused);
      length_mirror = length_word[Lb-1:0];
      check_registers();
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (pending_pairs.size() != 0 || req_valid || faded_pairs.size() != 0)
         @(negedge clock);
   endtask

   task automatic add_pair(input sample_type left, input sample_type right,
                           input bit restart, input bit block_end);
      alfo_pkg::req_payload_type pair;
      pair.left_in   = left;
      pair.right_in  = right;
      pair.restart   = restart;
      pair.block_end = block_end;
      pending_pairs.push_back(pair);
   endtask

   function automatic logic [Db-1:0] pick_start();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return 32'h8000_0000 | $urandom();
         default: return $urandom_range(0, 40);
      endcase
   endfunction

   // Length words carry random upper bits, which the block must ignore.
   function automatic logic [Db-1:0] pick_length();
      logic [Db-1:0] upper;
      upper = $urandom() & 32'hFF00_0000;
      case ($urandom_range(0, 9))
         0: return upper;
         1: return upper | 32'd1;
         2: return upper | 32'h00FF_FFFF;
         3: return $urandom();
         default: return upper | $urandom_range(2, 60);
      endcase
   endfunction

   initial begin : stimulus
      int sent;
      int phase;
      int count;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      check_registers();
      @(negedge clock);

      // Reset settings: fading from position zero over a very long span.
      add_pair(16'sh7fff, 16'sh8000, 1'b0, 1'b0);
      add_pair(16'sh8000, 16'sh7fff, 1'b0, 1'b1);
      add_pair(16'sh0000, 16'shffff, 1'b0, 1'b0);
      add_pair(16'sh0001, 16'shffff, 1'b1, 1'b0);
      add_pair(16'sh5555, 16'shaaaa, 1'b0, 1'b1);
      wait_drained();

      // Short fade that starts and ends inside one buffer.
      set_fade(32'd3, 32'd4);
      add_pair(16'sh7fff, 16'sh8000, 1'b1, 1'b0);
      add_pair(16'sh1234, 16'shedcc, 1'b0, 1'b0);
      add_pair(16'sh7fff, 16'sh8000, 1'b0, 1'b0);
      add_pair(16'sh7fff, 16'sh8000, 1'b0, 1'b0);
      add_pair(16'sh7fff, 16'sh8000, 1'b0, 1'b0);
      add_pair(16'shffff, 16'sh0001, 1'b0, 1'b0);
      add_pair(16'sh8000, 16'sh7fff, 1'b0, 1'b0);
      add_pair(16'sh7fff, 16'sh8000, 1'b0, 1'b1);
      add_pair(16'sh4000, 16'shc000, 1'b0, 1'b0);
      wait_drained();

      // Zero fade length: silence from the fade start on.
      set_fade(32'd2, 32'd0);
      add_pair(16'sh7fff, 16'sh8000, 1'b1, 1'b0);
      add_pair(16'sh7fff, 16'sh8000, 1'b0, 1'b0);
      add_pair(16'sh7fff, 16'sh8000, 1'b0, 1'b1);
      add_pair(16'sh8000, 16'sh7fff, 1'b0, 1'b0);
      wait_drained();

      // Largest start and length: the fade is never reached.
      set_fade(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_pair(16'sh8000, 16'sh7fff, 1'b0, 1'b1);
      add_pair(16'sh7fff, 16'sh8000, 1'b1, 1'b0);
      wait_drained();

      // Fade from zero over the largest length.
      set_fade(32'd0, 32'h5AFF_FFFF);
      add_pair(16'sh8000, 16'sh7fff, 1'b1, 1'b0);
      add_pair(16'sh7fff, 16'sh8000, 1'b0, 1'b1);
      wait_drained();

      // Random runs: each starts from position zero with a random fade start and length.
      sent = 0;
      phase = 0;
      while (sent < RandomPairs) begin
         wait_drained();
         set_fade(pick_start(), pick_length());
         sender_quiet   = (phase % 4 == 3);
         receiver_quiet = (phase % 5 == 2);
         count = $urandom_range(30, 110);
         for (int k = 0; k < count; k++) begin
            add_pair(pick_sample(), pick_sample(), k == 0 || $urandom_range(0, 39) == 0,
                     $urandom_range(0, 7) == 0);
         end
         sent += count;
         phase++;
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
